@@ design/slfbs_pkg.sv @@
// Package for the serial LCD frame byte streamer: payload structs, queue entry type,
// controller command codes and byte positions of the window set-up sequence.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slfbs_pkg;

  // Field widths.
  localparam int SIDE_W   = 9;
  localparam int COUNT_W  = 18;
  localparam int BYTE_W   = 8;
  localparam int RGB_W    = 24;
  localparam int OPCODE_W = 2;
  localparam int IDX_W    = 4;

  // Largest window side, and the reset size of the window.
  localparam logic [SIDE_W-1:0] MAX_SIDE     = SIDE_W'(480);
  localparam logic [SIDE_W-1:0] RESET_WIDTH  = SIDE_W'(320);
  localparam logic [SIDE_W-1:0] RESET_HEIGHT = SIDE_W'(240);

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIDE_W;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Controller command bytes.
  localparam logic [BYTE_W-1:0] CMD_COL_ADDR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_ROW_ADDR   = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_MEM_WRITE  = 8'h2C;
  localparam logic [BYTE_W-1:0] CMD_BRIGHTNESS = 8'h51;

  // Byte positions within the window set-up sequence.
  localparam logic [IDX_W-1:0] IDX_COL_CMD  = 4'd0;
  localparam logic [IDX_W-1:0] IDX_COL_S_HI = 4'd1;
  localparam logic [IDX_W-1:0] IDX_COL_S_LO = 4'd2;
  localparam logic [IDX_W-1:0] IDX_COL_E_HI = 4'd3;
  localparam logic [IDX_W-1:0] IDX_COL_E_LO = 4'd4;
  localparam logic [IDX_W-1:0] IDX_ROW_CMD  = 4'd5;
  localparam logic [IDX_W-1:0] IDX_ROW_S_HI = 4'd6;
  localparam logic [IDX_W-1:0] IDX_ROW_S_LO = 4'd7;
  localparam logic [IDX_W-1:0] IDX_ROW_E_HI = 4'd8;
  localparam logic [IDX_W-1:0] IDX_ROW_E_LO = 4'd9;
  localparam logic [IDX_W-1:0] IDX_MEM_WR   = 4'd10;

  // Byte positions of the two-byte transactions (pixel, brightness).
  localparam logic [IDX_W-1:0] IDX_FIRST = 4'd0;
  localparam logic [IDX_W-1:0] IDX_PAIR_LAST = 4'd1;

  // Input opcodes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_FRAME  = 2'd0,
    OP_PIXEL  = 2'd1,
    OP_BRIGHT = 2'd2
  } op_t;

  // Kind of work handed from the front to the back.
  typedef enum logic [1:0] {
    KIND_SETUP  = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_BRIGHT = 2'd2
  } kind_t;

  // Queue depth between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [RGB_W-1:0]    pixel_rgb;
    logic [BYTE_W-1:0]   level;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_data;
    logic              last;
    logic              frame_end;
  } out_item_t;

  // Queue entry. Set-up: data = {height-1, width-1}. Pixel: data[15:0] = RGB565.
  // Brightness: data[7:0] = level.
  typedef struct packed {
    kind_t                  kind;
    logic [2*SIDE_W-1:0]    data;
    logic                   frame_end;
  } desc_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic  full;
    logic  head_valid;
    desc_t head;
  } q_status_t;

endpackage

`default_nettype wire

@@ design/spi_lcd_frame_byte_streamer_top.sv @@
// Top level of the serial LCD frame byte streamer: front, descriptor queue and back.
// Depends on slfbs_pkg, slfbs_front, slfbs_queue and slfbs_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) carries frame start, pixel and
//   brightness transactions. Output channel (out_valid / out_stall / out_item) carries
//   one byte per transaction, tagged command or data, with a last flag per input item
//   and a frame_end flag on the low byte of the frame's final pixel.
//   cfg_we / cfg_index / cfg_wdata write the window width and height, saturated to
//   1..480; write them only while the block is idle.
// Timing:
//   The first byte of an item passes through the queue and then the output register. The back
//   end emits one byte per cycle while out_stall is low; a pixel or brightness item is 2
//   bytes and a frame start 11, so the back end's byte rate sets the item rate. Opcode 3 is
//   accepted and dropped. A two-entry queue lets the front accept while bytes drain.
// Reset and stall:
//   Reset empties the queue and the output register, clears the pixel counter and
//   restores a 320 x 240 window. While out_stall is high the output byte holds, the
//   queue fills, and in_stall rises once it is full.
`timescale 1ns / 1ps
`default_nettype none

module spi_lcd_frame_byte_streamer_top
  import slfbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item
);

  logic      push;
  logic      pop;
  desc_t     push_desc;
  q_status_t q_status;

  // Front: accepts and classifies input transactions.
  slfbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .q_full    (q_status.full),
    .in_stall  (in_stall),
    .push      (push),
    .push_desc (push_desc)
  );

  // Queue between front and back.
  slfbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .status    (q_status)
  );

  // Back: serializes descriptors into bytes.
  slfbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTH
  // The queue never takes a descriptor while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.full |-> !push)
    else $error("descriptor pushed into a full queue");

  // The back end only retires a descriptor that is present.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_status.head_valid)
    else $error("descriptor popped from an empty queue");

  // A frame end byte is always the final data byte of its item.
  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.frame_end) |-> (out_item.last && out_item.is_data))
    else $error("frame end flagged on a byte that is not a final data byte");

  // A new byte is loaded only after the previous one was taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("output byte changed while stalled");
`endif

endmodule

`default_nettype wire

@@ design/slfbs_front.sv @@
// Front end of the streamer: configuration registers, pixel counter and item classification.
// Depends on slfbs_pkg; pushes one work descriptor per useful input transaction.
`timescale 1ns / 1ps
`default_nettype none

module slfbs_front
  import slfbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  input  wire in_item_t              in_item,
  input  wire logic                  q_full,
  output logic                       in_stall,
  output logic                       push,
  output desc_t                      push_desc
);

  logic [SIDE_W-1:0]  width_r;
  logic [SIDE_W-1:0]  height_r;
  logic [SIDE_W-1:0]  cfg_clamped;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] total;
  logic               accept;
  logic               wrap;
  logic [15:0]        rgb565;

  // Written values saturate into the legal side range.
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamped = SIDE_W'(1);
    end else if (cfg_wdata > MAX_SIDE) begin
      cfg_clamped = MAX_SIDE;
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_clamped;
        REG_HEIGHT: height_r <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // The input side waits only while the queue is full.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Pixel counting against the window area.
  assign total     = {{(COUNT_W-SIDE_W){1'b0}}, width_r} * {{(COUNT_W-SIDE_W){1'b0}}, height_r};
  assign count_inc = count_r + COUNT_W'(1);
  assign wrap      = (count_inc >= total);

  assign rgb565 = {in_item.pixel_rgb[23:19], in_item.pixel_rgb[15:10], in_item.pixel_rgb[7:3]};

  // Classify the transaction and build its descriptor.
  always_comb begin
    push      = 1'b0;
    push_desc = '{kind: KIND_SETUP, data: '0, frame_end: 1'b0};
    count_nxt = count_r;
    unique case (in_item.opcode)
      OP_FRAME: begin
        push           = accept;
        push_desc.kind = KIND_SETUP;
        push_desc.data = {height_r - SIDE_W'(1), width_r - SIDE_W'(1)};
        if (accept) begin
          count_nxt = '0;
        end
      end
      OP_PIXEL: begin
        push                = accept;
        push_desc.kind      = KIND_PIXEL;
        push_desc.data      = {{(2*SIDE_W-16){1'b0}}, rgb565};
        push_desc.frame_end = wrap;
        if (accept) begin
          count_nxt = wrap ? '0 : count_inc;
        end
      end
      OP_BRIGHT: begin
        push           = accept;
        push_desc.kind = KIND_BRIGHT;
        push_desc.data = {{(2*SIDE_W-BYTE_W){1'b0}}, in_item.level};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/slfbs_queue.sv @@
// Short descriptor queue between front and back of the streamer.
// Depends on slfbs_pkg for the entry and status types.
`timescale 1ns / 1ps
`default_nettype none

module slfbs_queue
  import slfbs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output q_status_t  status
);

  desc_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;

  assign status.full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign status.head_valid = (cnt_r != '0);
  assign status.head       = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  // Occupancy tracking.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/slfbs_back.sv @@
// Back end of the streamer: walks each descriptor byte by byte into the output register.
// Depends on slfbs_pkg; reads the queue head and pops it as its final byte is loaded.
`timescale 1ns / 1ps
`default_nettype none

module slfbs_back
  import slfbs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_status_t q_status,
  output logic           pop,
  input  wire logic      out_stall,
  output logic           out_valid,
  output out_item_t      out_item
);

  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  last_idx;
  logic              fire;
  logic              last_byte;
  logic              out_valid_r;
  out_item_t         out_item_r;
  out_item_t         byte_nxt;
  logic [SIDE_W-1:0] wm;
  logic [SIDE_W-1:0] hm;

  assign wm = q_status.head.data[SIDE_W-1:0];
  assign hm = q_status.head.data[2*SIDE_W-1:SIDE_W];

  // Final byte position for the head descriptor.
  always_comb begin
    unique case (q_status.head.kind)
      KIND_SETUP: last_idx = IDX_MEM_WR;
      default:    last_idx = IDX_PAIR_LAST;
    endcase
  end

  assign last_byte = (idx_r == last_idx);
  assign fire      = q_status.head_valid && (!out_valid_r || !out_stall);
  assign pop       = fire && last_byte;

  // Byte generator for the current position.
  always_comb begin
    byte_nxt = '{out_byte: '0, is_data: 1'b1, last: last_byte, frame_end: 1'b0};
    unique case (q_status.head.kind)
      KIND_SETUP: begin
        unique case (idx_r) inside
          IDX_COL_CMD: begin
            byte_nxt.out_byte = CMD_COL_ADDR;
            byte_nxt.is_data  = 1'b0;
          end
          IDX_ROW_CMD: begin
            byte_nxt.out_byte = CMD_ROW_ADDR;
            byte_nxt.is_data  = 1'b0;
          end
          IDX_MEM_WR: begin
            byte_nxt.out_byte = CMD_MEM_WRITE;
            byte_nxt.is_data  = 1'b0;
          end
          IDX_COL_E_HI: byte_nxt.out_byte = BYTE_W'(wm >> BYTE_W);
          IDX_COL_E_LO: byte_nxt.out_byte = wm[BYTE_W-1:0];
          IDX_ROW_E_HI: byte_nxt.out_byte = BYTE_W'(hm >> BYTE_W);
          IDX_ROW_E_LO: byte_nxt.out_byte = hm[BYTE_W-1:0];
          IDX_COL_S_HI, IDX_COL_S_LO, IDX_ROW_S_HI, IDX_ROW_S_LO: begin
            byte_nxt.out_byte = '0;
          end
          default: byte_nxt.out_byte = '0;
        endcase
      end
      KIND_PIXEL: begin
        if (idx_r == IDX_FIRST) begin
          byte_nxt.out_byte = q_status.head.data[15:8];
        end else begin
          byte_nxt.out_byte  = q_status.head.data[7:0];
          byte_nxt.frame_end = q_status.head.frame_end;
        end
      end
      KIND_BRIGHT: begin
        if (idx_r == IDX_FIRST) begin
          byte_nxt.out_byte = CMD_BRIGHTNESS;
          byte_nxt.is_data  = 1'b0;
        end else begin
          byte_nxt.out_byte = q_status.head.data[BYTE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Byte position counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (fire) begin
      idx_r <= last_byte ? '0 : idx_r + IDX_W'(1);
    end
  end

  // Output register: refilled whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= byte_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

@@ verif/slfbs_checker.sv @@
// Checker for the serial LCD frame byte streamer: watches the configuration port and both
// channels, predicts the byte stream and compares it with what the block emits.
// Depends on slfbs_pkg.
`timescale 1ns / 1ps

module slfbs_checker
  import slfbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_item,
  output int                    fail_count,
  output int                    pending
);

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the window registers and the pixel counter.
  logic [SIDE_W-1:0]  win_width;
  logic [SIDE_W-1:0]  win_height;
  logic [COUNT_W-1:0] pix_count;

  // Bytes the block still owes, oldest first.
  out_item_t lcd_bytes_due[$];
  int        err_count;

  // Written sides are held to 1..MAX_SIDE.
  function automatic logic [SIDE_W-1:0] saturate_side(input logic [SIDE_W-1:0] v);
    if (v == '0) return SIDE_W'(1);
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic out_item_t lcd_byte(input logic [BYTE_W-1:0] b, input logic d,
                                         input logic l, input logic f);
    out_item_t o;
    o.out_byte  = b;
    o.is_data   = d;
    o.last      = l;
    o.frame_end = f;
    return o;
  endfunction

  // Window set-up: column range, row range, then memory write.
  task automatic queue_window_setup();
    logic [SIDE_W-1:0] col_end;
    logic [SIDE_W-1:0] row_end;
    col_end = win_width - 1'b1;
    row_end = win_height - 1'b1;
    lcd_bytes_due.push_back(lcd_byte(CMD_COL_ADDR, 1'b0, 1'b0, 1'b0));
    lcd_bytes_due.push_back(lcd_byte('0, 1'b1, 1'b0, 1'b0));
    lcd_bytes_due.push_back(lcd_byte('0, 1'b1, 1'b0, 1'b0));
    lcd_bytes_due.push_back(lcd_byte(BYTE_W'(col_end >> 8), 1'b1, 1'b0, 1'b0));
    lcd_bytes_due.push_back(lcd_byte(col_end[7:0], 1'b1, 1'b0, 1'b0));
    lcd_bytes_due.push_back(lcd_byte(CMD_ROW_ADDR, 1'b0, 1'b0, 1'b0));
    lcd_bytes_due.push_back(lcd_byte('0, 1'b1, 1'b0, 1'b0));
    lcd_bytes_due.push_back(lcd_byte('0, 1'b1, 1'b0, 1'b0));
    lcd_bytes_due.push_back(lcd_byte(BYTE_W'(row_end >> 8), 1'b1, 1'b0, 1'b0));
    lcd_bytes_due.push_back(lcd_byte(row_end[7:0], 1'b1, 1'b0, 1'b0));
    lcd_bytes_due.push_back(lcd_byte(CMD_MEM_WRITE, 1'b0, 1'b1, 1'b0));
    pix_count = '0;
  endtask

  // Pixel: RGB565 high byte then low byte; the low byte carries the frame end.
  task automatic queue_pixel(input logic [RGB_W-1:0] rgb);
    logic [15:0]        rgb565;
    logic [COUNT_W-1:0] frame_pixels;
    logic [COUNT_W-1:0] next_count;
    logic               fend;
    rgb565       = {rgb[23:19], rgb[15:10], rgb[7:3]};
    frame_pixels = COUNT_W'(win_width) * COUNT_W'(win_height);
    next_count   = pix_count + 1'b1;
    fend         = (next_count >= frame_pixels);
    if (fend) next_count = '0;
    pix_count = next_count;
    lcd_bytes_due.push_back(lcd_byte(rgb565[15:8], 1'b1, 1'b0, 1'b0));
    lcd_bytes_due.push_back(lcd_byte(rgb565[7:0], 1'b1, 1'b1, fend));
  endtask

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Everything is sampled at the rising edge, before the block's outputs move.
  always @(posedge clk) begin
    out_item_t due;
    logic      bad;
    if (!rst_n) begin
      win_width  = RESET_WIDTH;
      win_height = RESET_HEIGHT;
      pix_count  = '0;
      lcd_bytes_due.delete();
    end else begin
      // Register writes.
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) begin
          win_width = saturate_side(cfg_wdata);
        end else if (cfg_index == REG_HEIGHT) begin
          win_height = saturate_side(cfg_wdata);
        end
      end

      // Accepted input transaction: queue the bytes it causes.
      if (in_valid && !in_stall) begin
        case (op_t'(in_item.opcode))
          OP_FRAME: queue_window_setup();
          OP_PIXEL: queue_pixel(in_item.pixel_rgb);
          OP_BRIGHT: begin
            lcd_bytes_due.push_back(lcd_byte(CMD_BRIGHTNESS, 1'b0, 1'b0, 1'b0));
            lcd_bytes_due.push_back(lcd_byte(in_item.level, 1'b1, 1'b1, 1'b0));
          end
          default: ;
        endcase
      end

      // Accepted output transaction: compare with the oldest owed byte.
      if (out_valid && !out_stall) begin
        if (lcd_bytes_due.size() == 0) begin
          note_error($sformatf("unexpected byte=%02h data=%0b last=%0b frame_end=%0b",
                               out_item.out_byte, out_item.is_data, out_item.last,
                               out_item.frame_end));
        end else begin
          due = lcd_bytes_due.pop_front();
          bad = (out_item.out_byte !== due.out_byte) || (out_item.is_data !== due.is_data) ||
                (out_item.last !== due.last) || (out_item.frame_end !== due.frame_end);
          if (bad) begin
            note_error($sformatf({"mismatch: expected byte=%02h data=%0b last=%0b ",
                                  "frame_end=%0b, got byte=%02h data=%0b last=%0b ",
                                  "frame_end=%0b"},
                                 due.out_byte, due.is_data, due.last, due.frame_end,
                                 out_item.out_byte, out_item.is_data, out_item.last,
                                 out_item.frame_end));
          end
        end
      end
    end
    pending    <= lcd_bytes_due.size();
    fail_count <= err_count;
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the serial LCD frame byte streamer: clock, reset, configuration
// writes, input stimulus, output stall pattern and the verdict.
// Depends on slfbs_pkg, spi_lcd_frame_byte_streamer_top and slfbs_checker.
`timescale 1ns / 1ps

module tb;
  import slfbs_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int TARGET_ITEMS = 230;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;

  int fail_count;
  int pending;
  int items_sent = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  // Raw values last written to the window registers.
  logic [CFG_DATA_W-1:0] cur_w = RESET_WIDTH;
  logic [CFG_DATA_W-1:0] cur_h = RESET_HEIGHT;

  spi_lcd_frame_byte_streamer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  slfbs_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Receiver stall pattern; held low while the stimulus asks for a calm stretch.
  initial begin
    int run_left;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (run_left > 0) begin
        run_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        run_left = gap_cycles();
      end else begin
        out_stall <= 1'b0;
        run_left = $urandom_range(0, 8);
      end
    end
  end

  // Side pick for the random phases: mostly tiny windows so frames complete.
  function automatic logic [CFG_DATA_W-1:0] pick_side();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return CFG_DATA_W'($urandom_range(1, 5));
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return CFG_DATA_W'(1);
        2: return MAX_SIDE;
        default: return '1;
      endcase
    end
    if (r < 80) return CFG_DATA_W'($urandom_range(6, 20));
    return CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1));
  endfunction

  function automatic int side_of(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return int'(MAX_SIDE);
    return int'(v);
  endfunction

  task automatic idle_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one transaction and hold it until accepted.
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [RGB_W-1:0] rgb,
                           input logic [BYTE_W-1:0] lvl);
    in_item_t it;
    it.opcode    = op;
    it.pixel_rgb = rgb;
    it.level     = lvl;
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
    idle_gap(calm ? 0 : gap_cycles());
  endtask

  task automatic send_pixel();
    send_item(OP_PIXEL, RGB_W'($urandom), BYTE_W'($urandom));
  endtask

  // Stop sending until every owed byte has come out.
  task automatic hold_off();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block drained and settled.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_WIDTH) cur_w = val;
    else cur_h = val;
  endtask

  task automatic set_window(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    hold_off();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  initial begin
    int frame_pixels;
    int npix;
    int r;
    int k;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset window, color extremes, brightness extremes, unused opcode.
    send_item(OP_FRAME, '1, '1);
    send_item(OP_PIXEL, '0, '1);
    send_item(OP_PIXEL, '1, '0);
    send_item(OP_PIXEL, 24'hAA55AA, 8'h55);
    send_item(OP_PIXEL, 24'h55AA55, 8'hAA);
    send_item(OP_BRIGHT, '1, '0);
    send_item(OP_BRIGHT, '0, '1);
    send_item(OP_BRIGHT, 24'h5A5A5A, 8'hA5);
    send_item(OP_UNUSED, '1, '1);
    send_item(OP_UNUSED, '0, '0);

    // Zero sides saturate to a single-pixel window: every pixel ends a frame,
    // with or without a frame start.
    set_window('0, '0);
    send_pixel();
    send_pixel();
    send_item(OP_FRAME, '0, '0);

    // Oversized sides saturate to the largest window.
    set_window('1, CFG_DATA_W'(481));
    send_item(OP_FRAME, '0, '0);
    set_window(MAX_SIDE, CFG_DATA_W'(1));
    send_item(OP_FRAME, '0, '0);

    // A full 2 x 2 frame, then the counter carries on past the wrap.
    set_window(CFG_DATA_W'(2), CFG_DATA_W'(2));
    send_item(OP_FRAME, '0, '0);
    for (k = 0; k < 5; k++) send_pixel();

    // Window shrunk mid-frame: the next pixel lands beyond the new size.
    set_window(CFG_DATA_W'(4), CFG_DATA_W'(4));
    send_item(OP_FRAME, '0, '0);
    for (k = 0; k < 6; k++) send_pixel();
    set_window(CFG_DATA_W'(2), CFG_DATA_W'(2));
    send_pixel();

    // Random phases, each with its own window and idling mood.
    while (items_sent < TARGET_ITEMS) begin
      hold_off();
      calm = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clk);
      case ($urandom_range(0, 3))
        1: write_reg(REG_WIDTH, pick_side());
        2: write_reg(REG_HEIGHT, pick_side());
        default: begin
          write_reg(REG_WIDTH, pick_side());
          write_reg(REG_HEIGHT, pick_side());
        end
      endcase
      calm = ($urandom_range(0, 4) == 0);
      frame_pixels = side_of(cur_w) * side_of(cur_h);

      if ($urandom_range(0, 3) != 0) begin
        send_item(OP_FRAME, RGB_W'($urandom), BYTE_W'($urandom));
        npix = (frame_pixels <= 40) ? frame_pixels + $urandom_range(0, 3)
                                    : $urandom_range(8, 30);
      end else begin
        npix = $urandom_range(5, 20);
      end

      for (k = 0; k < npix; k++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_item(OP_BRIGHT, RGB_W'($urandom), BYTE_W'($urandom));
        end else if (r < 12) begin
          send_item(OP_UNUSED, RGB_W'($urandom), BYTE_W'($urandom));
        end else if (r < 15) begin
          send_item(OPCODE_W'($urandom_range(0, 3)), RGB_W'($urandom), BYTE_W'($urandom));
        end else begin
          send_pixel();
        end
        if ($urandom_range(0, 49) == 0) hold_off();
      end
    end

    // Drain, let the block settle, then decide.
    hold_off();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/slfbs_pkg.sv
design/slfbs_front.sv
design/slfbs_queue.sv
design/slfbs_back.sv
design/spi_lcd_frame_byte_streamer_top.sv
verif/slfbs_checker.sv
verif/tb.sv
